/* hdl/midi_event_byte_encoder_macros.svh */
// assertion macros for the midi event byte encoder
// expects i_clk and i_rst_n in the scope of each use
`ifndef MIDI_EVENT_BYTE_ENCODER_MACROS_SVH
`define MIDI_EVENT_BYTE_ENCODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MEBE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("midi encoder check failed");

// next-cycle implication, checked outside reset
`define MEBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error("midi encoder check failed");

`endif

/* hdl/mebe_pkg.sv */
// shared types, codes and byte constants for the midi event byte encoder
// no dependencies
package mebe_pkg;

    localparam int unsigned FrameBytes = 11;
    localparam int unsigned VlqBytes   = 4;
    localparam int unsigned BodyBytes  = 7;

    localparam logic [2:0] CMD_NOTE     = 3'd0;
    localparam logic [2:0] CMD_TEMPO    = 3'd1;
    localparam logic [2:0] CMD_TIME_SIG = 3'd2;
    localparam logic [2:0] CMD_PROGRAM  = 3'd3;
    localparam logic [2:0] CMD_EOT      = 3'd4;

    localparam logic       REG_CHANNEL = 1'b0;

    localparam logic [7:0] VLQ_MORE       = 8'h80;
    localparam logic [3:0] ST_NOTE_OFF    = 4'h8;
    localparam logic [3:0] ST_NOTE_ON     = 4'h9;
    localparam logic [3:0] ST_PROGRAM     = 4'hC;
    localparam logic [7:0] META           = 8'hFF;
    localparam logic [7:0] META_TEMPO     = 8'h51;
    localparam logic [7:0] META_TEMPO_LEN = 8'h03;
    localparam logic [7:0] META_SIG       = 8'h58;
    localparam logic [7:0] META_SIG_LEN   = 8'h04;
    localparam logic [7:0] SIG_CLOCKS     = 8'h18;
    localparam logic [7:0] SIG_32ND       = 8'h08;
    localparam logic [7:0] META_EOT       = 8'h2F;
    localparam logic [7:0] META_EOT_LEN   = 8'h00;

    typedef struct packed {
        logic [2:0]  command;
        logic [27:0] delta_time;
        logic [7:0]  pitch;
        logic [7:0]  velocity;
        logic [23:0] tempo_us;
        logic [7:0]  sig_numerator;
        logic [7:0]  sig_denominator;
        logic [7:0]  program_number;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_item;

    // byte 0 goes out first; len counts the bytes still to send
    typedef struct packed {
        logic [FrameBytes-1:0][7:0] bytes;
        logic [3:0]                 len;
    } t_frame;

endpackage

/* hdl/mebe_encode.sv */
// builds the full byte frame of one event: delta vlq followed by the event body
// depends on mebe_pkg
module mebe_encode (
    input  mebe_pkg::t_in_item item,
    input  logic [3:0]         channel,
    output mebe_pkg::t_frame   frame,
    output logic               known
);

    logic [3:0][6:0]                                w_grp;
    logic [2:0]                                     w_vlq_len;
    logic [mebe_pkg::VlqBytes-1:0][7:0]             w_vlq;
    logic [mebe_pkg::BodyBytes-1:0][7:0]            w_body;
    logic [2:0]                                     w_body_len;
    logic [3:0]                                     w_idx;

    assign w_grp[0] = item.delta_time[6:0];
    assign w_grp[1] = item.delta_time[13:7];
    assign w_grp[2] = item.delta_time[20:14];
    assign w_grp[3] = item.delta_time[27:21];

    assign known = (item.command <= mebe_pkg::CMD_EOT);

    always_comb begin
        if (w_grp[3] != 7'd0) begin
            w_vlq_len = 3'd4;
        end else if (w_grp[2] != 7'd0) begin
            w_vlq_len = 3'd3;
        end else if (w_grp[1] != 7'd0) begin
            w_vlq_len = 3'd2;
        end else begin
            w_vlq_len = 3'd1;
        end
    end

    // most significant group first, continuation bit on all but the final byte
    always_comb begin
        w_vlq = '0;
        case (w_vlq_len)
            3'd4: begin
                w_vlq[0] = mebe_pkg::VLQ_MORE | {1'b0, w_grp[3]};
                w_vlq[1] = mebe_pkg::VLQ_MORE | {1'b0, w_grp[2]};
                w_vlq[2] = mebe_pkg::VLQ_MORE | {1'b0, w_grp[1]};
                w_vlq[3] = {1'b0, w_grp[0]};
            end
            3'd3: begin
                w_vlq[0] = mebe_pkg::VLQ_MORE | {1'b0, w_grp[2]};
                w_vlq[1] = mebe_pkg::VLQ_MORE | {1'b0, w_grp[1]};
                w_vlq[2] = {1'b0, w_grp[0]};
            end
            3'd2: begin
                w_vlq[0] = mebe_pkg::VLQ_MORE | {1'b0, w_grp[1]};
                w_vlq[1] = {1'b0, w_grp[0]};
            end
            default: begin
                w_vlq[0] = {1'b0, w_grp[0]};
            end
        endcase
    end

    always_comb begin
        w_body     = '0;
        w_body_len = 3'd3;
        unique case (item.command)
            mebe_pkg::CMD_NOTE: begin
                w_body[0]  = {(item.velocity != 8'd0) ? mebe_pkg::ST_NOTE_ON
                                                      : mebe_pkg::ST_NOTE_OFF, channel};
                w_body[1]  = item.pitch;
                w_body[2]  = item.velocity;
                w_body_len = 3'd3;
            end
            mebe_pkg::CMD_TEMPO: begin
                w_body[0]  = mebe_pkg::META;
                w_body[1]  = mebe_pkg::META_TEMPO;
                w_body[2]  = mebe_pkg::META_TEMPO_LEN;
                w_body[3]  = item.tempo_us[23:16];
                w_body[4]  = item.tempo_us[15:8];
                w_body[5]  = item.tempo_us[7:0];
                w_body_len = 3'd6;
            end
            mebe_pkg::CMD_TIME_SIG: begin
                w_body[0]  = mebe_pkg::META;
                w_body[1]  = mebe_pkg::META_SIG;
                w_body[2]  = mebe_pkg::META_SIG_LEN;
                w_body[3]  = item.sig_numerator;
                w_body[4]  = item.sig_denominator;
                w_body[5]  = mebe_pkg::SIG_CLOCKS;
                w_body[6]  = mebe_pkg::SIG_32ND;
                w_body_len = 3'd7;
            end
            mebe_pkg::CMD_PROGRAM: begin
                w_body[0]  = {mebe_pkg::ST_PROGRAM, channel};
                w_body[1]  = item.program_number;
                w_body_len = 3'd2;
            end
            default: begin
                // end of track; unused codes are dropped through known
                w_body[0]  = mebe_pkg::META;
                w_body[1]  = mebe_pkg::META_EOT;
                w_body[2]  = mebe_pkg::META_EOT_LEN;
                w_body_len = 3'd3;
            end
        endcase
    end

    // body starts right after the vlq bytes
    always_comb begin
        frame.bytes = '0;
        w_idx       = '0;
        for (int k = 0; k < mebe_pkg::FrameBytes; k++) begin
            w_idx = 4'(k) - {1'b0, w_vlq_len};
            if (4'(k) < {1'b0, w_vlq_len}) begin
                frame.bytes[k] = w_vlq[k[1:0]];
            end else if (w_idx < 4'(mebe_pkg::BodyBytes)) begin
                frame.bytes[k] = w_body[w_idx[2:0]];
            end
        end
        frame.len = {1'b0, w_vlq_len} + {1'b0, w_body_len};
    end

endmodule

/* hdl/mebe_serializer.sv */
// holds one frame; sends a byte per cycle to the output register unless stalled
// depends on mebe_pkg
module mebe_serializer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  mebe_pkg::t_frame    i_frame,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mebe_pkg::t_out_item o_out_item
);

    logic                r_frame_valid, n_frame_valid;
    mebe_pkg::t_frame    r_frame, n_frame;
    logic                r_out_valid, n_out_valid;
    mebe_pkg::t_out_item r_out, n_out;
    logic                w_emit;
    logic                w_done;

    assign w_emit = r_frame_valid && (!r_out_valid || i_out_ready);
    assign w_done = w_emit && (r_frame.len == 4'd1);
    // a new frame may land in the same cycle the old one sends its final byte
    assign o_free = !r_frame_valid || w_done;

    always_comb begin
        n_frame_valid = r_frame_valid;
        n_frame       = r_frame;
        if (i_load) begin
            n_frame_valid = 1'b1;
            n_frame       = i_frame;
        end else if (w_done) begin
            n_frame_valid = 1'b0;
        end else if (w_emit) begin
            n_frame.bytes = r_frame.bytes >> 8;
            n_frame.len   = r_frame.len - 4'd1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_emit) begin
            n_out_valid     = 1'b1;
            n_out.out_byte  = r_frame.bytes[0];
            n_out.last_byte = (r_frame.len == 4'd1);
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_frame_valid <= n_frame_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* hdl/midi_event_byte_encoder.sv */
// Turns one MIDI track event per transaction into its byte stream, one byte per
// output transaction with last_byte set on the final byte of the event. An event
// is the delta time as a 1 to 4 byte VLQ followed by its body, 3 to 11 bytes in
// all. The output register sends one byte per cycle while the sink is ready,
// and with a ready sink events run back to back with no gap. The first byte
// of an event passes through the frame register and then the output register.
// Command codes 5 to 7 are taken and produce nothing. The channel register
// (APB, offset 0) is added to note and program change status bytes.
// depends on mebe_pkg, mebe_encode, mebe_serializer and the macros header
`include "midi_event_byte_encoder_macros.svh"

module midi_event_byte_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mebe_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mebe_pkg::t_out_item o_out_item
);

    logic [3:0]       r_chan, n_chan;
    logic             w_cfg_write;
    mebe_pkg::t_frame w_frame;
    logic             w_known;
    logic             w_load;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && (paddr[2] == mebe_pkg::REG_CHANNEL);

    always_comb begin
        n_chan = r_chan;
        if (w_cfg_write) begin
            n_chan = pwdata[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= 4'd0;
        end else begin
            r_chan <= n_chan;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == mebe_pkg::REG_CHANNEL) begin
            prdata = {28'd0, r_chan};
        end
    end

    mebe_encode u_encode (
        .item    (i_in_item),
        .channel (r_chan),
        .frame   (w_frame),
        .known   (w_known)
    );

    assign w_load = i_in_valid && o_in_ready && w_known;

    mebe_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_frame     (w_frame),
        .o_free      (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // a byte the sink has not taken stays put
    `MEBE_ASSERT_NEXT(a_out_holds, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))
    // an accepted event reaches the output through the frame and output registers
    `MEBE_ASSERT_NOW(a_event_reaches_output, w_load, ##2 o_out_valid)
    // channel only moves on a register write
    `MEBE_ASSERT_NEXT(a_channel_holds, !w_cfg_write, $stable(r_chan))

endmodule
